### design/wrv_pkg.sv
`default_nettype none
package wrv_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [3:0] reason;
  } out_item_t;

  localparam logic [1:0] VerdictValid = 2'd0;
  localparam logic [1:0] VerdictTrunc = 2'd1;
  localparam logic [1:0] VerdictBad   = 2'd2;

  localparam logic [3:0] RsnOk        = 4'd0;
  localparam logic [3:0] RsnSmall     = 4'd1;
  localparam logic [3:0] RsnHdrShort  = 4'd2;
  localparam logic [3:0] RsnMagic     = 4'd3;
  localparam logic [3:0] RsnRiffSmall = 4'd4;
  localparam logic [3:0] RsnRiffBig   = 4'd5;
  localparam logic [3:0] RsnChkShort  = 4'd6;
  localparam logic [3:0] RsnChkEnd    = 4'd7;
  localparam logic [3:0] RsnFmtSmall  = 4'd8;
  localparam logic [3:0] RsnFmtShort  = 4'd9;
  localparam logic [3:0] RsnFmtBad    = 4'd10;
  localparam logic [3:0] RsnDataFirst = 4'd11;
  localparam logic [3:0] RsnProbe     = 4'd12;
  localparam logic [3:0] RsnNone      = 4'd13;

  localparam logic [0:0] CfgFileSize   = 1'd0;
  localparam logic [0:0] CfgProbeLimit = 1'd1;

  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;
  localparam logic [31:0] MagicRiff = 32'h4646_4952;
  localparam logic [31:0] MagicWave = 32'h4556_4157;

endpackage
`default_nettype wire

### design/wrv_fifo.sv
`default_nettype none
module wrv_fifo import wrv_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     wr_valid_i,
  output logic          wr_ready_o,
  input  wire in_item_t wr_data_i,
  output logic          rd_valid_o,
  input  wire logic     rd_ready_i,
  output in_item_t      rd_data_o
);
  // Two-entry queue; full throughput with registered ready.
  in_item_t  mem_q [2];
  logic      wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

### design/wrv_parser.sv
`default_nettype none
module wrv_parser import wrv_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [35:0] file_size_i,
  input  wire logic [24:0] probe_limit_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_data_o
);
  localparam logic [2:0] PhIdle = 3'd0;
  localparam logic [2:0] PhHead = 3'd1;
  localparam logic [2:0] PhChdr = 3'd2;
  localparam logic [2:0] PhFmt  = 3'd3;
  localparam logic [2:0] PhSkip = 3'd4;
  localparam logic [2:0] PhChk  = 3'd5; // chunk header just completed
  localparam logic [2:0] PhFchk = 3'd6; // fmt body just completed
  localparam logic [2:0] PhMul  = 3'd7; // byte rate product being checked

  logic [2:0]  ph_q, ph_d;
  logic [33:0] off_q, off_d, rend_q, rend_d, next_q, next_d;
  logic [31:0] len_q, len_d, tag_q, tag_d;
  logic [3:0]  pos_q, pos_d;
  logic [7:0]  fb_q [16];
  logic        fseen_q, fseen_d, magic_q, magic_d;
  logic        eos_q, eos_d;
  logic        ov_q, ov_d;
  out_item_t   od_q, od_d;
  logic        fbok_q, fbok_d;
  logic [47:0] prod_q;

  // No byte is accepted during the post-processing phases.
  logic busy;
  assign busy = (ph_q == PhChk) || (ph_q == PhFchk) || (ph_q == PhMul);
  assign in_ready_o  = !busy && (!ov_q || out_ready_i);
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  logic acc;
  assign acc = in_valid_i && in_ready_o;

  logic [33:0] wend;
  assign wend = (rend_q < {9'd0, probe_limit_i}) ? rend_q : {9'd0, probe_limit_i};

  logic [15:0] code, chans, align, bits;
  logic [31:0] rate, brate;
  assign code  = {fb_q[1], fb_q[0]};
  assign chans = {fb_q[3], fb_q[2]};
  assign rate  = {fb_q[7], fb_q[6], fb_q[5], fb_q[4]};
  assign brate = {fb_q[11], fb_q[10], fb_q[9], fb_q[8]};
  assign align = {fb_q[13], fb_q[12]};
  assign bits  = {fb_q[15], fb_q[14]};

  always_comb begin
    logic [7:0] d;
    logic       emit;
    logic [1:0] v;
    logic [3:0] r;
    logic [34:0] re;
    logic [17:0] exp_align;
    logic [34:0] n8;
    d = in_data_i.data_byte;
    emit = 1'b0; v = VerdictValid; r = RsnOk;
    ph_d = ph_q; off_d = off_q; rend_d = rend_q; next_d = next_q;
    len_d = len_q; tag_d = tag_q; pos_d = pos_q; fseen_d = fseen_q;
    magic_d = magic_q; eos_d = eos_q; fbok_d = fbok_q;
    re = '0; n8 = '0;
    exp_align = {16'd0, chans[1:0]} * {5'd0, bits[15:3]};
    ov_d = ov_q && !out_ready_i;
    od_d = od_q;

    if (busy) begin
      case (ph_q)
        PhChk: begin
          ph_d = PhChdr;
          if (next_q > rend_q || {2'd0, next_q} > file_size_i) begin
            emit = 1'b1; v = VerdictTrunc; r = RsnChkEnd;
          end else if (tag_q == TagFmt) begin
            if (len_q < 32'd16) begin
              emit = 1'b1; v = VerdictBad; r = RsnFmtSmall;
            end else begin
              ph_d = PhFmt; pos_d = '0;
            end
          end else if (tag_q == TagData) begin
            emit = 1'b1;
            if (!fseen_q) begin v = VerdictBad; r = RsnDataFirst; end
          end else begin
            ph_d = PhIdle; // resolved below
          end
        end
        PhFchk: begin
          fbok_d = (code == 16'd1 || code == 16'd3) && (chans == 16'd1 || chans == 16'd2)
                   && rate != 32'd0 && bits != 16'd0 && bits[2:0] == 3'd0
                   && {2'd0, align} == exp_align;
          ph_d = PhMul;
        end
        default: begin // PhMul
          if (!fbok_q || prod_q[47:32] != 16'd0 || prod_q[31:0] != brate) begin
            emit = 1'b1; v = VerdictBad; r = RsnFmtBad;
          end else begin
            fseen_d = 1'b1; ph_d = PhIdle;
          end
        end
      endcase
      // Common end-of-chunk handling for a plain chunk or a good fmt body.
      if (!emit && ph_d == PhIdle) begin
        n8 = {1'b0, next_q} + 35'd8;
        if (next_q > wend) begin
          emit = 1'b1; v = VerdictBad; r = RsnProbe;
        end else if (n8 > {1'b0, wend}) begin
          emit = 1'b1; v = VerdictBad; r = RsnNone;
        end else if (off_q == next_q) begin
          ph_d = PhChdr; pos_d = '0; tag_d = '0; len_d = '0;
        end else ph_d = PhSkip;
      end
      // The fmt fields are judged before an early end is reported.
      if (!emit && eos_q && ph_q != PhFchk) begin
        emit = 1'b1; v = VerdictTrunc;
        r = (ph_d == PhFmt) ? RsnFmtShort : RsnChkShort;
      end
      if (emit) ph_d = PhIdle;
    end else if (acc) begin
      eos_d = in_data_i.end_of_stream;
      if (in_data_i.first_byte) begin
        off_d = '0; rend_d = '0; next_d = '0; len_d = '0; tag_d = '0; pos_d = '0;
        fseen_d = 1'b0; magic_d = 1'b1; ph_d = PhHead;
        if (file_size_i < 36'd12) begin
          emit = 1'b1; v = VerdictTrunc; r = RsnSmall; ph_d = PhIdle;
        end
      end
      if (!emit && ph_d != PhIdle) begin
        off_d = off_d + 34'd1;
        case (ph_d)
          PhHead: begin
            if (pos_d < 4'd4) begin
              if (d != MagicRiff[8*pos_d[1:0] +: 8]) magic_d = 1'b0;
            end else if (pos_d < 4'd8) len_d[8*pos_d[1:0] +: 8] = d;
            else if (d != MagicWave[8*pos_d[1:0] +: 8]) magic_d = 1'b0;
            pos_d = pos_d + 4'd1;
            if (pos_d == 4'd12) begin
              re = {3'd0, len_d} + 35'd8;
              if (!magic_d) begin emit = 1'b1; v = VerdictBad; r = RsnMagic; end
              else if (re < 35'd12) begin emit = 1'b1; v = VerdictBad; r = RsnRiffSmall; end
              else if ({1'b0, re} > file_size_i) begin
                emit = 1'b1; v = VerdictTrunc; r = RsnRiffBig;
              end else begin
                rend_d = re[33:0]; next_d = 34'd12;
                if ((re[33:0] < {9'd0, probe_limit_i} ? re[33:0] : {9'd0, probe_limit_i})
                    < 34'd20) begin
                  emit = 1'b1; v = VerdictBad; r = RsnNone;
                end else begin
                  ph_d = PhChdr; pos_d = '0; tag_d = '0; len_d = '0;
                end
              end
            end
          end
          PhChdr: begin
            if (pos_d < 4'd4) tag_d[8*pos_d[1:0] +: 8] = d;
            else len_d[8*pos_d[1:0] +: 8] = d;
            pos_d = pos_d + 4'd1;
            if (pos_d == 4'd8) ph_d = PhChk;
          end
          PhFmt: begin
            pos_d = pos_d + 4'd1;
            if (pos_d == 4'd0) ph_d = PhFchk;
          end
          default: begin // PhSkip
            if (off_d >= next_q) begin
              ph_d = PhChdr; pos_d = '0; tag_d = '0; len_d = '0;
            end
          end
        endcase
        // Chunk end is computed from the updated length.
        if (ph_d == PhChk)
          next_d = next_q + 34'd8 + {2'd0, len_d} + {33'd0, len_d[0]};
        if (!emit && ph_d != PhChk && ph_d != PhFchk && in_data_i.end_of_stream) begin
          emit = 1'b1; v = VerdictTrunc;
          r = (ph_d == PhHead) ? RsnHdrShort : (ph_d == PhFmt) ? RsnFmtShort : RsnChkShort;
        end
        if (emit) ph_d = PhIdle;
      end
    end
    if (emit) begin
      ov_d = 1'b1; od_d.verdict = v; od_d.reason = r;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && ph_q == PhFmt && !in_data_i.first_byte) fb_q[pos_q] <= in_data_i.data_byte;
    prod_q <= {16'd0, rate} * {32'd0, align};
    od_q <= od_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhIdle; off_q <= '0; rend_q <= '0; next_q <= '0; len_q <= '0;
      tag_q <= '0; pos_q <= '0; fseen_q <= 1'b0; magic_q <= 1'b1; eos_q <= 1'b0;
      ov_q <= 1'b0; fbok_q <= 1'b0;
    end else begin
      ph_q <= ph_d; off_q <= off_d; rend_q <= rend_d; next_q <= next_d; len_q <= len_d;
      tag_q <= tag_d; pos_q <= pos_d; fseen_q <= fseen_d; magic_q <= magic_d;
      eos_q <= eos_d; ov_q <= ov_d; fbok_q <= fbok_d;
    end
  end
endmodule
`default_nettype wire

### design/wav_riff_header_validator_unit.sv
`default_nettype none
// RIFF/WAVE header checker. File bytes enter one per transfer through a
// two-entry queue; the parser consumes one byte per cycle unless a stalled
// verdict holds it, and pauses after each chunk header (chunk limit compares)
// and after the 16 fmt bytes (field checks, then the byte-rate multiply).
// At most one verdict per file is presented on the output register; bytes
// after it are dropped until the next first byte.
module wav_riff_header_validator_unit import wrv_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [35:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_data_o
);
  logic [35:0] file_size_q;
  logic [24:0] probe_limit_q;
  logic        q_valid, q_ready;
  in_item_t    q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q <= '0;
      probe_limit_q <= 25'd65536;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgFileSize:   file_size_q <= cfg_data_i;
        CfgProbeLimit: probe_limit_q <= cfg_data_i[24:0];
        default: ;
      endcase
    end
  end

  wrv_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(in_valid_i), .wr_ready_o(in_ready_o), .wr_data_i(in_data_i),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_data)
  );

  wrv_parser u_parser (
    .clk_i, .rst_ni,
    .file_size_i(file_size_q), .probe_limit_i(probe_limit_q),
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_data_i(q_data),
    .out_valid_o, .out_ready_i, .out_data_o
  );

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");
  a_verdict_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.verdict != 2'd3 && out_data_o.reason <= RsnNone)
    else $error("bad result code");
`endif
endmodule
`default_nettype wire
